// File: rtl/core/fpst_pkg.sv
// fpst_pkg: shared constants, codes and types of the prefix sum table core
// depends on nothing; imported by every module under rtl/core
package fpst_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // field widths fixed by the interface
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 10;
   localparam int LIMIT_W = 11;

   // walk position: one bit above the index so an upward step never wraps
   localparam int POS_W = INDEX_W + 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
   localparam logic [LIMIT_W-1:0] BOUND_MAX   = LIMIT_W'(TABLE_DEPTH);

   // operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic step;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic walk_live;
      logic op_query;
      logic rsp_free;
   } status_type;

endpackage

// File: rtl/core/fpst_ctrl.sv
// fpst_ctrl: sequencer for clearing pass, accept, tree walk and response
// depends on fpst_pkg
module fpst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fpst_pkg::status_type status,
   output fpst_pkg::cmd_type    cmd
);
   import fpst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!status.walk_live) state_in = status.op_query ? ST_RESP : ST_IDLE;
         end
         ST_RESP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
         end
         ST_RESP: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // once the clearing pass is over it never comes back
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> state_ff != ST_CLEAR)
      else $error("clearing pass re-entered");

endmodule

// File: rtl/core/fpst_datapath.sv
// fpst_datapath: partial sum memory, walk position, accumulator, limit and result register
// depends on fpst_pkg
module fpst_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  fpst_pkg::cmd_type            cmd,
   output fpst_pkg::status_type         status,
   input  logic                         req_operation,
   input  logic [fpst_pkg::INDEX_W-1:0] req_index,
   input  logic signed [fpst_pkg::DATA_W-1:0] req_delta,
   input  logic                         csr_valid,
   input  logic [fpst_pkg::LIMIT_W-1:0] csr_index_limit,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic signed [fpst_pkg::DATA_W-1:0] rsp_prefix_total
);
   import fpst_pkg::*;

   logic [DATA_W-1:0] mem [TABLE_DEPTH];

   logic [LIMIT_W-1:0] limit_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               op_ff;
   logic [DATA_W-1:0]  delta_ff;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic               qlive_ff, qlive_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [POS_W-1:0]   rd_addr_ff;
   logic [DATA_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;

   logic [LIMIT_W-1:0] bound;
   logic [POS_W-1:0]   pos_up;
   logic [POS_W-1:0]   pos_low;
   logic               live;
   logic               rd_en;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DATA_W-1:0]  wr_data;

   // limit above the table depth acts as the depth
   assign bound = (limit_ff > BOUND_MAX) ? BOUND_MAX : limit_ff;

   assign pos_up  = pos_ff | (pos_ff + POS_W'(1));
   assign pos_low = pos_ff & (pos_ff + POS_W'(1));

   assign live = (op_ff == OP_ADD) ? (POS_W'(pos_ff) < POS_W'(bound)) : qlive_ff;

   // one read per walk step; entries past the table read as zero on a query
   assign rd_en = cmd.step && live && (pos_ff < POS_W'(TABLE_DEPTH));

   always_comb begin
      pos_in      = pos_ff;
      qlive_in    = qlive_ff;
      rd_valid_in = 1'b0;
      acc_in      = acc_ff;
      if (cmd.load) begin
         pos_in   = POS_W'(req_index);
         qlive_in = 1'b1;
         acc_in   = '0;
      end else begin
         if (cmd.step && live) begin
            rd_valid_in = rd_en;
            if (op_ff == OP_ADD) begin
               pos_in = pos_up;
            end else begin
               pos_in   = pos_low - POS_W'(1);
               qlive_in = (pos_low != '0);
            end
         end
         if (rd_valid_ff && op_ff == OP_QUERY) acc_in = acc_ff + rd_data_ff;
      end
   end

   // write port: clearing pass, else the add of the entry read last cycle
   always_comb begin
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = rd_valid_ff && (op_ff == OP_ADD);
         wr_addr = rd_addr_ff[ADDR_W-1:0];
         wr_data = rd_data_ff + delta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[pos_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         qlive_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) limit_ff <= csr_index_limit;
         if (cmd.clear) clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         rd_valid_ff <= rd_valid_in;
         qlive_ff    <= qlive_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      acc_ff     <= acc_in;
      rd_addr_ff <= pos_ff;
      if (cmd.load) begin
         op_ff    <= req_operation;
         delta_ff <= req_delta;
      end
      if (cmd.rsp_load) rsp_data_ff <= acc_ff;
   end

   assign status.clear_last = (clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign status.walk_live  = live;
   assign status.op_query   = (op_ff == OP_QUERY);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prefix_total = rsp_data_ff;

   // an add walks strictly upward, so the read never meets the pending write
   a_add_up: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && rd_en && op_ff == OP_ADD) |-> (pos_ff > rd_addr_ff))
      else $error("add walk not increasing");

   // no table read while the clearing pass owns the write port
   a_clear_no_read: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !rd_en && !cmd.load)
      else $error("table access during clearing pass");

   // only queries produce a result
   a_rsp_query: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (op_ff == OP_QUERY) && !rd_valid_ff)
      else $error("result loaded for an add or before the walk drained");

endmodule

// File: rtl/core/fenwick_prefix_sum_table_core.sv
// fenwick_prefix_sum_table_core: top level of the binary indexed prefix sum table
// depends on fpst_pkg, fpst_ctrl and fpst_datapath
//
// channel   dir   handshake            payload
// req       in    req_valid/req_stall  req_operation, req_index, req_delta
// rsp       out   rsp_valid/rsp_stall  rsp_prefix_total
// csr       in    csr_valid/csr_ready  csr_index_limit
//
// an item passes an accept state, then a walk with one step per table entry visited (at most
// eleven for 1024 entries, an add from index zero) and a closing step; a query then
// loads the result register. the walk rate is set by the single table memory: one
// registered read and one write per cycle, each write in the cycle after its read
// after reset a clearing pass zeroes every table entry, with req stalled;
// csr writes are taken at any time. a waiting result holds in its register
// while the next item is accepted; a new query's result waits for it to drain
module fenwick_prefix_sum_table_core (
   input  logic                                clock,
   input  logic                                reset,
   // request beats
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [fpst_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [fpst_pkg::DATA_W-1:0]  req_delta,
   // response beats
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fpst_pkg::DATA_W-1:0]  rsp_prefix_total,
   // limit register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpst_pkg::LIMIT_W-1:0]        csr_index_limit
);
   import fpst_pkg::*;

   cmd_type    cmd;
   status_type status;

   // the limit register is always writable
   assign csr_ready = 1'b1;

   // sequencer: clearing pass, accept, walk, response
   fpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table memory, walk position, accumulator and result register
   fpst_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_index        (req_index),
      .req_delta        (req_delta),
      .csr_valid        (csr_valid),
      .csr_index_limit  (csr_index_limit),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_prefix_total (rsp_prefix_total)
   );

endmodule

// File: tb/sv/fenwick_prefix_sum_table_core_tb.sv
// fenwick_prefix_sum_table_core_tb: self-checking bench for the prefix sum table core
// drives add and query beats and limit writes, predicts every prefix total and compares in order
// depends on fpst_pkg and fenwick_prefix_sum_table_core
module fenwick_prefix_sum_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpst_pkg::*;

   // the drain pause lets the block finish its last item, with room to spare
   localparam int DRAIN_CYCLES = 32;
   // receiver hold-off used to fill the block and push back on the request side
   localparam int unsigned HOLD_CYCLES = 300;
   // far beyond the slowest correct run, including the clearing pass after reset
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 165;
   // ring of owed totals; the block never holds more than a few queries
   localparam int unsigned OWED_DEPTH = 16;

   // limit values outside the nominal range that the field still allows
   localparam logic [LIMIT_W-1:0] LIMIT_ZERO      = '0;
   localparam logic [LIMIT_W-1:0] LIMIT_FIELD_MAX = '1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_operation = OP_ADD;
   logic [INDEX_W-1:0]         req_index = '0;
   logic signed [DATA_W-1:0]   req_delta = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]   rsp_prefix_total;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [LIMIT_W-1:0]         csr_index_limit = LIMIT_RESET;

   // shadow of the table and of the limit register
   logic [DATA_W-1:0]          shadow_sums [TABLE_DEPTH];
   logic [LIMIT_W-1:0]         shadow_limit = LIMIT_RESET;
   // prefix totals still owed by the block, oldest first
   logic signed [DATA_W-1:0]   owed_totals [OWED_DEPTH];
   int unsigned                owed_wr = 0;
   int unsigned                owed_rd = 0;

   int unsigned                cycle_count = 0;
   int unsigned                errors = 0;
   int unsigned                adds_sent = 0;
   int unsigned                queries_sent = 0;
   int unsigned                totals_checked = 0;
   int unsigned                limit_writes = 0;

   // idling controls: sender and receiver rates in percent of cycles, and the receiver hold-off
   int unsigned                sender_idle_pct = 0;
   int unsigned                receiver_stall_pct = 0;
   int unsigned                hold_target = 0;
   int unsigned                hold_elapsed = 0;

   fenwick_prefix_sum_table_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_index        (req_index),
      .req_delta        (req_delta),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_prefix_total (rsp_prefix_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index_limit  (csr_index_limit)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // runaway guard
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver side: a long hold-off once when asked, otherwise random stalls
   always @(posedge clock) begin
      if (hold_elapsed < hold_target) begin
         rsp_stall    <= 1'b1;
         hold_elapsed <= hold_elapsed + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // result checker: every accepted beat against the oldest owed total
   always @(posedge clock) begin
      logic signed [DATA_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_wr == owed_rd) begin
            $error("prefix_total: no result expected, got %0d", rsp_prefix_total);
            errors++;
         end else begin
            want = owed_totals[owed_rd % OWED_DEPTH];
            owed_rd++;
            totals_checked++;
            if (rsp_prefix_total !== want) begin
               $error("prefix_total: expected %0d, got %0d", want, rsp_prefix_total);
               errors++;
            end
         end
      end
   end

   // upward walk: i -> i | (i+1), bounded by the limit clipped to the table size
   function automatic void apply_point_add(logic [INDEX_W-1:0] idx,
                                           logic [DATA_W-1:0] amount);
      int unsigned pos;
      int unsigned bound;
      pos   = idx;
      bound = (shadow_limit > BOUND_MAX) ? TABLE_DEPTH : shadow_limit;
      while (pos < bound) begin
         shadow_sums[pos] = shadow_sums[pos] + amount;
         pos = pos | (pos + 1);
      end
   endfunction

   // downward walk: i -> (i & (i+1)) - 1 until below zero, wrapping sum
   function automatic logic signed [DATA_W-1:0] prefix_total_at(logic [INDEX_W-1:0] idx);
      logic [DATA_W-1:0] total;
      int                i;
      total = '0;
      i     = idx;
      while (i >= 0) begin
         if (i < TABLE_DEPTH)
            total = total + shadow_sums[i];
         i = (i & (i + 1)) - 1;
      end
      return total;
   endfunction

   // offer one request beat and hold it until the block takes it
   task automatic send_item(logic op, logic [INDEX_W-1:0] idx, logic signed [DATA_W-1:0] delta);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_index     <= idx;
      req_delta     <= delta;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // beat taken at this edge: update the shadow and owe a total for queries
      if (op == OP_QUERY) begin
         owed_totals[owed_wr % OWED_DEPTH] = prefix_total_at(idx);
         owed_wr++;
         queries_sent++;
      end else begin
         apply_point_add(idx, delta);
         adds_sent++;
      end
   endtask

   // let everything in flight finish, then write the limit
   task automatic write_limit(logic [LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      while (owed_wr != owed_rd) @(posedge clock);
      // adds leave no result behind, so give the last walk time to close
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_index_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      shadow_limit  = value;
      limit_writes++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_delta();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3, 4: return $signed($urandom_range(200)) - 100;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return INDEX_W'($urandom_range(15));
         default: return INDEX_W'($urandom_range(TABLE_DEPTH - 1));
      endcase
   endfunction

   // empty table, extremes of index and delta, wrap-around of the sums
   task automatic test_directed_basics();
      send_item(OP_QUERY, 10'd0,    pick_delta());
      send_item(OP_QUERY, 10'd1023, pick_delta());
      send_item(OP_ADD,   10'd0,    32'sh7fff_ffff);
      send_item(OP_ADD,   10'd1023, 32'sh8000_0000);
      send_item(OP_ADD,   10'd511,  -32'sd1);
      send_item(OP_ADD,   10'd512,  32'sd1);
      send_item(OP_ADD,   10'd0,    32'sh8000_0000);
      send_item(OP_QUERY, 10'd0,    32'sd0);
      send_item(OP_QUERY, 10'd511,  32'sd0);
      send_item(OP_QUERY, 10'd512,  -32'sd1);
      send_item(OP_QUERY, 10'd1022, 32'sh7fff_ffff);
      send_item(OP_QUERY, 10'd1023, 32'sh8000_0000);
   endtask

   // limit of zero, limit one, limit above the table, index at and past the limit
   task automatic test_limit_cases();
      write_limit(LIMIT_ZERO);
      send_item(OP_ADD,   10'd5,    32'sd7);
      send_item(OP_QUERY, 10'd1023, 32'sd0);
      write_limit(LIMIT_W'(1));
      send_item(OP_ADD,   10'd0,    32'sd3);
      send_item(OP_ADD,   10'd1,    32'sd9);
      send_item(OP_QUERY, 10'd0,    32'sd0);
      send_item(OP_QUERY, 10'd1,    32'sd0);
      write_limit(LIMIT_FIELD_MAX);
      send_item(OP_ADD,   10'd1023, 32'sd100);
      send_item(OP_QUERY, 10'd1023, 32'sd0);
      write_limit(LIMIT_W'(600));
      send_item(OP_ADD,   10'd599,  32'sd5);
      send_item(OP_ADD,   10'd600,  32'sd11);
      send_item(OP_QUERY, 10'd1023, 32'sd0);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      write_limit(LIMIT_RESET);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_target       <= HOLD_CYCLES;
      repeat (40) begin
         send_item(($urandom_range(3) != 0) ? OP_QUERY : OP_ADD, pick_index(), pick_delta());
      end
   endtask

   // mixed random traffic over several limits and idling patterns
   task automatic test_random_traffic();
      logic [LIMIT_W-1:0] phase_limit;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       phase_limit = LIMIT_RESET;
            1:       phase_limit = LIMIT_W'($urandom_range(1023, 1));
            2:       phase_limit = LIMIT_FIELD_MAX;
            3:       phase_limit = LIMIT_W'($urandom_range(1023, 512));
            4:       phase_limit = LIMIT_W'(1);
            5:       phase_limit = BOUND_MAX;
            6:       phase_limit = LIMIT_W'($urandom_range(TABLE_DEPTH * 2 - 1));
            default: phase_limit = LIMIT_RESET;
         endcase
         write_limit(phase_limit);
         // idling pattern changes every two phases
         case (phase / 2)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
            default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            send_item($urandom_range(1) ? OP_QUERY : OP_ADD, pick_index(), pick_delta());
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) shadow_sums[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_limit_cases();
      test_backpressure();
      test_random_traffic();

      // wait out every owed total, then let the last walk settle
      req_valid <= 1'b0;
      while (owed_wr != owed_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d adds and %0d queries, %0d totals compared, %0d limit writes",
               adds_sent, queries_sent, totals_checked, limit_writes);
      $display("limits from zero to the field maximum, with and without idling and a long hold-off");
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
rtl/core/fpst_pkg.sv
rtl/core/fpst_ctrl.sv
rtl/core/fpst_datapath.sv
rtl/core/fenwick_prefix_sum_table_core.sv
tb/sv/fenwick_prefix_sum_table_core_tb.sv
